// ===== src/cpss_pkg.sv =====
// Package for the segment-segment closest point block.
// Holds register map constants, division mode codes and fixed field widths.
// Used by the top level and the checker under src; depends on nothing.
package cpss_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_LSB = 2;

  // Register index of the degenerate threshold.
  localparam logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] REG_DEGEN_THR = 1'b0;
  localparam logic [CFG_DATA_W-1:0] DEGEN_THR_RESET = 32'd429497;

  // The squared distance is always Q32.32 and saturates.
  localparam int DIST_W = 64;
  localparam int DIFF_W = 34;
  localparam int SQ_IN_W = 32;

  // What the second divider computes for an item.
  typedef logic [1:0] div_mode_t;
  localparam div_mode_t DIV_NONE = 2'd0;
  localparam div_mode_t DIV_S = 2'd1;
  localparam div_mode_t DIV_T = 2'd2;

endpackage

// ===== src/cpss_mul.sv =====
// Two-stage signed multiplier built from four half-width partial products.
// Partial products are registered, then summed in the second stage.
// Uses no package items.
module cpss_mul #(
  parameter int W = 68
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int H = (W + 1) / 2;
  localparam int HW = W - H;

  logic [H-1:0] al, bl;
  logic signed [HW-1:0] ah, bh;
  logic [2*H-1:0] ll_r;
  logic signed [H+HW:0] lh_r, hl_r;
  logic signed [2*HW-1:0] hh_r;
  logic signed [2*W-1:0] p_r;
  logic signed [2*W-1:0] ll_x, mid_x, hh_x;

  assign al = a[H-1:0];
  assign bl = b[H-1:0];
  assign ah = a[W-1:H];
  assign bh = b[W-1:H];

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= al * bl;
      lh_r <= $signed({1'b0, al}) * bh;
      hl_r <= ah * $signed({1'b0, bl});
      hh_r <= ah * bh;
    end
  end

  always_comb begin
    ll_x = $signed((2*W)'(ll_r));
    mid_x = (2*W)'(lh_r) + (2*W)'(hl_r);
    hh_x = (2*W)'(hh_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (hh_x <<< (2*H)) + (mid_x <<< H) + ll_x;
    end
  end

  assign p = p_r;

endmodule

// ===== src/cpss_div.sv =====
// Pipelined clamped divider: clamp(n/d, 0, 1) truncated to F fraction bits.
// One register stage for the range check, then one per quotient bit.
// Uses no package items.
module cpss_div #(
  parameter int W = 138,
  parameter int F = 16,
  parameter int PW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] in_num,
  input  logic signed [W-1:0] in_den,
  input  logic [PW-1:0]       in_pay,
  output logic                out_valid,
  output logic [F:0]          out_q,
  output logic [PW-1:0]       out_pay
);

  logic          v_r    [0:F];
  logic [W-1:0]  rem_r  [0:F];
  logic [W-1:0]  den_r  [0:F];
  logic [F-1:0]  q_r    [0:F];
  logic          zero_r [0:F];
  logic          one_r  [0:F];
  logic [PW-1:0] pay_r  [0:F];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= in_num;
      den_r[0] <= in_den;
      q_r[0] <= '0;
      zero_r[0] <= (in_num <= $signed(W'(0)));
      one_r[0] <= (in_num >= in_den);
      pay_r[0] <= in_pay;
    end
  end

  for (genvar k = 1; k <= F; k++) begin : g_step
    logic [W-1:0] trial;
    logic ge;

    // The remainder stays below the divisor, so the top bit is free to drop.
    always_comb begin
      trial = {rem_r[k-1][W-2:0], 1'b0};
      ge = (trial >= den_r[k-1]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (trial - den_r[k-1]) : trial;
        den_r[k] <= den_r[k-1];
        q_r[k] <= {q_r[k-1][F-2:0], ge};
        zero_r[k] <= zero_r[k-1];
        one_r[k] <= one_r[k-1];
        pay_r[k] <= pay_r[k-1];
      end
    end
  end

  always_comb begin
    if (zero_r[F]) begin
      out_q = '0;
    end else if (one_r[F]) begin
      out_q = {1'b1, {F{1'b0}}};
    end else begin
      out_q = {1'b0, q_r[F]};
    end
  end

  assign out_valid = v_r[F];
  assign out_pay = pay_r[F];

endmodule

// ===== src/closest_points_segment_segment.sv =====
// Closest points between two 3D segments (signed Q16.16 endpoints) with clamped
// parameters, closest points and a saturating squared distance. A fully
// pipelined datapath takes one segment pair every cycle unless the output
// stalls; s and t come from two bit-per-stage dividers. A stalled output
// freezes the whole pipeline, empty stages included, and holds off the input
// until the waiting result item is taken.
module closest_points_segment_segment #(
  parameter int COORD_WIDTH = 32,
  parameter int PARAM_FRAC_BITS = 16,
  localparam int IN_W = ((12 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_RAW = 2 * (PARAM_FRAC_BITS + 1) + 6 * COORD_WIDTH + cpss_pkg::DIST_W,
  localparam int OUT_W = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic clk,
  input  logic rst_n,
  // first/second start/end x,y,z from the lowest bit up
  input  logic [IN_W-1:0] in_tdata,
  input  logic in_tvalid,
  output logic in_tready,
  // first_param, second_param, first_point_x/y/z, second_point_x/y/z,
  // distance_sq from the lowest bit up, zero padded
  output logic [OUT_W-1:0] out_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [cpss_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [cpss_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [cpss_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic cfg_pready
);

  localparam int CW = COORD_WIDTH;
  localparam int F = PARAM_FRAC_BITS;
  localparam int D = CW + 1;
  localparam int P = 2 * D;
  localparam int S = P + 2;
  localparam int W1 = 2 * S + 2;
  localparam int W2 = S + F + 3;
  localparam int BS_W = S + F + 2;
  localparam int M_W = D + F + 2;

  typedef struct packed {
    logic [2:0][CW-1:0] p0;
    logic [2:0][CW-1:0] q0;
    logic [2:0][D-1:0] d0;
    logic [2:0][D-1:0] d1;
    logic [S-1:0] a;
    logic [S-1:0] b;
    logic [S-1:0] c;
    logic [S-1:0] e;
    logic [S-1:0] f;
    logic adeg;
    logic edeg;
    logic [F:0] s;
    logic [F:0] t;
  } ctx_t;

  typedef struct packed {
    logic [F:0] s;
    logic [F:0] t;
    logic [2:0][CW-1:0] c1;
    logic [2:0][CW-1:0] c2;
  } res_t;

  typedef struct packed {
    logic dz;
    ctx_t ctx;
  } pay1_t;

  typedef struct packed {
    cpss_pkg::div_mode_t mode;
    ctx_t ctx;
  } pay2_t;

  // Configuration
  logic [cpss_pkg::CFG_DATA_W-1:0] thr_r;
  logic [cpss_pkg::CFG_ADDR_W-cpss_pkg::CFG_IDX_LSB-1:0] cfg_idx;

  assign cfg_idx = cfg_paddr[cpss_pkg::CFG_ADDR_W-1:cpss_pkg::CFG_IDX_LSB];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= cpss_pkg::DEGEN_THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_idx == cpss_pkg::REG_DEGEN_THR) begin
      thr_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_idx == cpss_pkg::REG_DEGEN_THR) ? thr_r : '0;

  // Pipeline control: every stage moves together unless the last one is
  // full and the output register cannot take it.
  logic adv, out_free;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;
  logic v11_r, v12_r, v13_r, v14_r, v15_r, out_valid_r;
  logic dv1, dv2;

  assign out_free = !out_valid_r || out_tready;
  assign adv = !v15_r || out_free;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0; v10_r <= 1'b0;
      v11_r <= 1'b0; v12_r <= 1'b0; v13_r <= 1'b0; v14_r <= 1'b0;
      v15_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= dv1; v8_r <= v7_r; v9_r <= v8_r;
      v10_r <= v9_r; v11_r <= dv2; v12_r <= v11_r; v13_r <= v12_r;
      v14_r <= v13_r; v15_r <= v14_r;
    end
  end

  // Stage 1: direction vectors and start offset
  ctx_t ctx1_r, ctx1_nxt;
  logic [2:0][D-1:0] r1_r;

  always_comb begin
    ctx1_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      ctx1_nxt.p0[i] = in_tdata[i*CW +: CW];
      ctx1_nxt.q0[i] = in_tdata[(6+i)*CW +: CW];
      ctx1_nxt.d0[i] = D'($signed(in_tdata[(3+i)*CW +: CW])) -
                       D'($signed(in_tdata[i*CW +: CW]));
      ctx1_nxt.d1[i] = D'($signed(in_tdata[(9+i)*CW +: CW])) -
                       D'($signed(in_tdata[(6+i)*CW +: CW]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx1_r <= ctx1_nxt;
      for (int i = 0; i < 3; i++) begin
        r1_r[i] <= D'($signed(in_tdata[i*CW +: CW])) -
                   D'($signed(in_tdata[(6+i)*CW +: CW]));
      end
    end
  end

  // Stage 2: the fifteen lane products of the five dot products
  ctx_t ctx2_r;
  logic signed [P-1:0] paa_r [3], pee_r [3], pff_r [3], pcc_r [3], pbb_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx2_r <= ctx1_r;
      for (int i = 0; i < 3; i++) begin
        paa_r[i] <= $signed(ctx1_r.d0[i]) * $signed(ctx1_r.d0[i]);
        pee_r[i] <= $signed(ctx1_r.d1[i]) * $signed(ctx1_r.d1[i]);
        pff_r[i] <= $signed(ctx1_r.d1[i]) * $signed(r1_r[i]);
        pcc_r[i] <= $signed(ctx1_r.d0[i]) * $signed(r1_r[i]);
        pbb_r[i] <= $signed(ctx1_r.d0[i]) * $signed(ctx1_r.d1[i]);
      end
    end
  end

  // Stage 3: dot product sums
  ctx_t ctx3_r, ctx3_nxt;

  always_comb begin
    ctx3_nxt = ctx2_r;
    ctx3_nxt.a = S'(paa_r[0]) + S'(paa_r[1]) + S'(paa_r[2]);
    ctx3_nxt.e = S'(pee_r[0]) + S'(pee_r[1]) + S'(pee_r[2]);
    ctx3_nxt.f = S'(pff_r[0]) + S'(pff_r[1]) + S'(pff_r[2]);
    ctx3_nxt.c = S'(pcc_r[0]) + S'(pcc_r[1]) + S'(pcc_r[2]);
    ctx3_nxt.b = S'(pbb_r[0]) + S'(pbb_r[1]) + S'(pbb_r[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx3_r <= ctx3_nxt;
    end
  end

  // Stages 4 and 5: wide products for the line-line solution
  ctx_t ctx4_r, ctx4_nxt, ctx5_r;
  logic signed [2*S-1:0] m_ae, m_bb, m_bf, m_ce;

  cpss_mul #(.W(S)) u_mul_ae (.clk(clk), .en(adv), .a($signed(ctx3_r.a)),
    .b($signed(ctx3_r.e)), .p(m_ae));
  cpss_mul #(.W(S)) u_mul_bb (.clk(clk), .en(adv), .a($signed(ctx3_r.b)),
    .b($signed(ctx3_r.b)), .p(m_bb));
  cpss_mul #(.W(S)) u_mul_bf (.clk(clk), .en(adv), .a($signed(ctx3_r.b)),
    .b($signed(ctx3_r.f)), .p(m_bf));
  cpss_mul #(.W(S)) u_mul_ce (.clk(clk), .en(adv), .a($signed(ctx3_r.c)),
    .b($signed(ctx3_r.e)), .p(m_ce));

  always_comb begin
    ctx4_nxt = ctx3_r;
    ctx4_nxt.adeg = $signed(ctx3_r.a) <= $signed(S'(thr_r));
    ctx4_nxt.edeg = $signed(ctx3_r.e) <= $signed(S'(thr_r));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx4_r <= ctx4_nxt;
      ctx5_r <= ctx4_r;
    end
  end

  // Stage 6: numerator and denominator of s
  ctx_t ctx6_r;
  logic signed [W1-1:0] num6_r, den6_r;
  logic dz6_r;
  logic signed [W1-1:0] den6;

  assign den6 = W1'(m_ae) - W1'(m_bb);

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx6_r <= ctx5_r;
      num6_r <= W1'(m_bf) - W1'(m_ce);
      den6_r <= den6;
      dz6_r <= (den6 == '0);
    end
  end

  pay1_t pay1_in, pay1_out;
  logic [F:0] q1;

  assign pay1_in = '{dz: dz6_r, ctx: ctx6_r};

  cpss_div #(.W(W1), .F(F), .PW($bits(pay1_t))) u_div_s (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v6_r), .in_num(num6_r),
    .in_den(den6_r), .in_pay(pay1_in), .out_valid(dv1), .out_q(q1),
    .out_pay(pay1_out));

  // Stage 7: s from the line-line solution; parallel segments give zero
  ctx_t ctx7_r, ctx7_nxt, ctx8_r, ctx9_r;
  logic signed [BS_W-1:0] bs8_r;
  logic signed [W2-1:0] tn9_r, ed9_r;

  always_comb begin
    ctx7_nxt = pay1_out.ctx;
    ctx7_nxt.s = pay1_out.dz ? '0 : q1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx7_r <= ctx7_nxt;
      // Stage 8: b * s
      ctx8_r <= ctx7_r;
      bs8_r <= $signed(ctx7_r.b) * $signed({1'b0, ctx7_r.s});
      // Stage 9: numerator and denominator of t
      ctx9_r <= ctx8_r;
      tn9_r <= W2'(bs8_r) + (W2'($signed(ctx8_r.f)) <<< F);
      ed9_r <= W2'($signed(ctx8_r.e)) <<< F;
    end
  end

  // Stage 10: choose what the second divider works on
  ctx_t ctx10_r, ctx10;
  logic signed [W2-1:0] n10_r, d10_r, n10, d10;
  cpss_pkg::div_mode_t mode10_r, mode10;

  always_comb begin
    ctx10 = ctx9_r;
    n10 = W2'(0);
    d10 = W2'(1);
    mode10 = cpss_pkg::DIV_NONE;
    if (ctx9_r.adeg && ctx9_r.edeg) begin
      ctx10.s = '0;
      ctx10.t = '0;
    end else if (ctx9_r.adeg) begin
      ctx10.s = '0;
      mode10 = cpss_pkg::DIV_T;
      n10 = W2'($signed(ctx9_r.f));
      d10 = W2'($signed(ctx9_r.e));
    end else if (ctx9_r.edeg || tn9_r < 0) begin
      ctx10.t = '0;
      mode10 = cpss_pkg::DIV_S;
      n10 = -W2'($signed(ctx9_r.c));
      d10 = W2'($signed(ctx9_r.a));
    end else if (tn9_r > ed9_r) begin
      ctx10.t = {1'b1, {F{1'b0}}};
      mode10 = cpss_pkg::DIV_S;
      n10 = W2'($signed(ctx9_r.b)) - W2'($signed(ctx9_r.c));
      d10 = W2'($signed(ctx9_r.a));
    end else begin
      mode10 = cpss_pkg::DIV_T;
      n10 = tn9_r;
      d10 = ed9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx10_r <= ctx10;
      n10_r <= n10;
      d10_r <= d10;
      mode10_r <= mode10;
    end
  end

  pay2_t pay2_in, pay2_out;
  logic [F:0] q2;

  assign pay2_in = '{mode: mode10_r, ctx: ctx10_r};

  cpss_div #(.W(W2), .F(F), .PW($bits(pay2_t))) u_div_t (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v10_r), .in_num(n10_r),
    .in_den(d10_r), .in_pay(pay2_in), .out_valid(dv2), .out_q(q2),
    .out_pay(pay2_out));

  // Stage 11: final parameters
  ctx_t ctx11_r, ctx11_nxt, ctx12_r;
  logic signed [M_W-1:0] m1_r [3], m2_r [3];

  always_comb begin
    ctx11_nxt = pay2_out.ctx;
    case (pay2_out.mode)
      cpss_pkg::DIV_S: ctx11_nxt.s = q2;
      cpss_pkg::DIV_T: ctx11_nxt.t = q2;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx11_r <= ctx11_nxt;
      // Stage 12: direction times parameter
      ctx12_r <= ctx11_r;
      for (int i = 0; i < 3; i++) begin
        m1_r[i] <= $signed(ctx11_r.d0[i]) * $signed({1'b0, ctx11_r.s});
        m2_r[i] <= $signed(ctx11_r.d1[i]) * $signed({1'b0, ctx11_r.t});
      end
    end
  end

  // Stage 13: closest points and their difference
  res_t res13, res13_r, res14_r, res15_r;
  logic signed [cpss_pkg::DIFF_W-1:0] dx13 [3], dx13_r [3];
  logic signed [D+1:0] c1w [3], c2w [3];

  always_comb begin
    res13.s = ctx12_r.s;
    res13.t = ctx12_r.t;
    for (int i = 0; i < 3; i++) begin
      c1w[i] = (D+2)'($signed(ctx12_r.p0[i])) + (D+2)'(m1_r[i] >>> F);
      c2w[i] = (D+2)'($signed(ctx12_r.q0[i])) + (D+2)'(m2_r[i] >>> F);
      res13.c1[i] = c1w[i][CW-1:0];
      res13.c2[i] = c2w[i][CW-1:0];
      dx13[i] = cpss_pkg::DIFF_W'($signed(c1w[i][CW-1:0])) -
                cpss_pkg::DIFF_W'($signed(c2w[i][CW-1:0]));
    end
  end

  // Stage 14: per-lane squares; stage 15: saturating sum
  logic [cpss_pkg::DIST_W-1:0] sq14_r [3];
  logic sat14_r;
  logic [cpss_pkg::DIST_W-1:0] dist15_r;
  logic [cpss_pkg::DIFF_W-1:0] ad [3];
  logic sat14;
  logic [cpss_pkg::DIST_W+1:0] sum15;

  always_comb begin
    sat14 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ad[i] = dx13_r[i][cpss_pkg::DIFF_W-1] ? -dx13_r[i] : dx13_r[i];
      sat14 = sat14 | (|ad[i][cpss_pkg::DIFF_W-1:cpss_pkg::SQ_IN_W]);
    end
    sum15 = (cpss_pkg::DIST_W+2)'(sq14_r[0]) + (cpss_pkg::DIST_W+2)'(sq14_r[1]) +
            (cpss_pkg::DIST_W+2)'(sq14_r[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res13_r <= res13;
      for (int i = 0; i < 3; i++) begin
        dx13_r[i] <= dx13[i];
        sq14_r[i] <= ad[i][cpss_pkg::SQ_IN_W-1:0] * ad[i][cpss_pkg::SQ_IN_W-1:0];
      end
      res14_r <= res13_r;
      sat14_r <= sat14;
      res15_r <= res14_r;
      dist15_r <= (sat14_r || (|sum15[cpss_pkg::DIST_W+1:cpss_pkg::DIST_W])) ?
                  '1 : sum15[cpss_pkg::DIST_W-1:0];
    end
  end

  // Output register
  logic [OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= v15_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && v15_r) begin
      out_data_r <= OUT_W'({dist15_r, res15_r.c2, res15_r.c1, res15_r.t, res15_r.s});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

endmodule

// ===== src/cpss_check.sv =====
// Port-level checker for the segment-segment closest point block.
// Bound to the top level below; uses cpss_pkg for the register map.
module cpss_check #(
  parameter int COORD_WIDTH = 32,
  parameter int PARAM_FRAC_BITS = 16,
  localparam int OUT_RAW = 2 * (PARAM_FRAC_BITS + 1) + 6 * COORD_WIDTH + cpss_pkg::DIST_W,
  localparam int OUT_W = ((OUT_RAW + 7) / 8) * 8
) (
  input logic clk,
  input logic rst_n,
  input logic [OUT_W-1:0] out_tdata,
  input logic out_tvalid,
  input logic out_tready,
  input logic cfg_psel,
  input logic cfg_penable,
  input logic cfg_pwrite,
  input logic [cpss_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input logic [cpss_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input logic [cpss_pkg::CFG_DATA_W-1:0] cfg_prdata
);

  localparam int F = PARAM_FRAC_BITS;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  a_params: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[F:0] <= ONE) && (out_tdata[2*F+1:F+1] <= ONE))
    else $error("parameter outside [0,1]");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite &&
    cfg_paddr[cpss_pkg::CFG_ADDR_W-1:cpss_pkg::CFG_IDX_LSB] == cpss_pkg::REG_DEGEN_THR
    |=> (cfg_paddr[cpss_pkg::CFG_ADDR_W-1:cpss_pkg::CFG_IDX_LSB] != cpss_pkg::REG_DEGEN_THR)
        || (cfg_prdata == $past(cfg_pwdata)))
    else $error("threshold readback differs from last write");

endmodule

bind closest_points_segment_segment cpss_check #(
  .COORD_WIDTH(COORD_WIDTH),
  .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
) u_cpss_check (
  .clk(clk), .rst_n(rst_n), .out_tdata(out_tdata), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .cfg_psel(cfg_psel), .cfg_penable(cfg_penable),
  .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
  .cfg_prdata(cfg_prdata)
);

// ===== dv/closest_points_segment_segment_tb.sv =====
// Self-checking testbench for closest_points_segment_segment.
// Drives segment pairs over the input stream, computes the expected closest points in
// its own predictor and compares each result item; depends on src/cpss_pkg.sv and the RTL.
module closest_points_segment_segment_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int IN_W = 384;
  localparam int OUT_W = 296;
  localparam int LATENCY = 2 * FRAC + 18;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [16:0] ONE = 17'h10000;

  typedef logic signed [255:0] wide_t;
  typedef logic [IN_W-1:0] pair_t;

  typedef struct packed {
    logic [63:0] dist_sq;
    logic [31:0] q_z, q_y, q_x;
    logic [31:0] p_z, p_y, p_x;
    logic [16:0] t;
    logic [16:0] s;
  } closest_t;

  typedef struct {
    pair_t pair;
    bit    typed;
    closest_t result;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [cpss_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [cpss_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [cpss_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  closest_points_segment_segment dut (.*);

  always #6 clk = ~clk;

  closest_t expected_closest[$];
  logic [31:0] thresh = cpss_pkg::DEGEN_THR_RESET;
  int errors = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;

  function automatic logic [16:0] clamp_quot(wide_t n, wide_t d);
    if (n <= 0) return '0;
    if (n >= d) return ONE;
    return 17'((n <<< FRAC) / d);
  endfunction

  function automatic wide_t dot(longint u[3], longint v[3]);
    wide_t acc = '0;
    for (int i = 0; i < 3; i++) acc += wide_t'(u[i]) * wide_t'(v[i]);
    return acc;
  endfunction

  function automatic closest_t closest_of(pair_t pr);
    longint p0[3], q0[3], d0[3], d1[3], r[3], c1[3], c2[3];
    wide_t a, e, f, b, c, den, tn;
    logic [16:0] s, t;
    logic [65:0] dist_acc;
    bit sat;
    closest_t res;
    for (int i = 0; i < 3; i++) begin
      p0[i] = longint'($signed(pr[32*i +: 32]));
      q0[i] = longint'($signed(pr[32*(6+i) +: 32]));
      d0[i] = longint'($signed(pr[32*(3+i) +: 32])) - p0[i];
      d1[i] = longint'($signed(pr[32*(9+i) +: 32])) - q0[i];
      r[i] = p0[i] - q0[i];
    end
    a = dot(d0, d0);
    e = dot(d1, d1);
    f = dot(d1, r);
    c = dot(d0, r);
    b = dot(d0, d1);
    s = '0;
    t = '0;
    if (a <= wide_t'({1'b0, thresh})) begin
      if (e > wide_t'({1'b0, thresh})) t = clamp_quot(f, e);
    end else if (e <= wide_t'({1'b0, thresh})) begin
      s = clamp_quot(-c, a);
    end else begin
      den = a * e - b * b;
      if (den != 0) s = clamp_quot(b * f - c * e, den);
      tn = b * wide_t'({1'b0, s}) + (f <<< FRAC);
      if (tn < 0) begin
        s = clamp_quot(-c, a);
      end else if (tn > (e <<< FRAC)) begin
        t = ONE;
        s = clamp_quot(b - c, a);
      end else begin
        t = clamp_quot(tn, e <<< FRAC);
      end
    end
    dist_acc = '0;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      longint dx;
      longint unsigned ad;
      c1[i] = p0[i] + ((d0[i] * longint'(s)) >>> FRAC);
      c2[i] = q0[i] + ((d1[i] * longint'(t)) >>> FRAC);
      dx = c1[i] - c2[i];
      ad = (dx < 0) ? -dx : dx;
      if (ad > 64'hFFFF_FFFF) sat = 1'b1;
      else dist_acc += ad * ad;
    end
    if (sat || (|dist_acc[65:64])) dist_acc = {2'b00, {64{1'b1}}};
    res.s = s;
    res.t = t;
    res.p_x = c1[0][31:0];
    res.p_y = c1[1][31:0];
    res.p_z = c1[2][31:0];
    res.q_x = c2[0][31:0];
    res.q_y = c2[1][31:0];
    res.q_z = c2[2][31:0];
    res.dist_sq = dist_acc[63:0];
    return res;
  endfunction

  function automatic pair_t make_pair(int p0x, int p0y, int p0z, int p1x, int p1y, int p1z,
                                      int q0x, int q0y, int q0z, int q1x, int q1y, int q1z);
    return {q1z, q1y, q1x, q0z, q0y, q0x, p1z, p1y, p1x, p0z, p0y, p0x};
  endfunction

  // Random pair; the mix favors geometry that reaches the clamping branches.
  function automatic pair_t random_pair();
    pair_t pr;
    int span, k;
    for (int i = 0; i < 12; i++) begin
      span = (i % 3 == 0) ? 1 << $urandom_range(4, 24) : span;
      pr[32*i +: 32] = $urandom_range(0, 2 * span) - span;
    end
    case ($urandom_range(0, 9))
      0: for (int i = 0; i < 12; i++) pr[32*i +: 32] = $urandom();
      1: for (int i = 0; i < 3; i++)
           pr[32*(3+i) +: 32] = pr[32*i +: 32] + $urandom_range(0, 6) - 3;
      2: for (int i = 0; i < 3; i++)
           pr[32*(9+i) +: 32] = pr[32*(6+i) +: 32] + $urandom_range(0, 6) - 3;
      3, 4: begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < 3; i++)
          pr[32*(9+i) +: 32] = pr[32*(6+i) +: 32] +
            (($urandom_range(0, 1) ? k : -k) * (pr[32*(3+i) +: 32] - pr[32*i +: 32]));
      end
      default: ;
    endcase
    return pr;
  endfunction

  task automatic cfg_write(logic [cpss_pkg::CFG_ADDR_W-1:0] addr, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr[cpss_pkg::CFG_ADDR_W-1:cpss_pkg::CFG_IDX_LSB] == cpss_pkg::REG_DEGEN_THR)
      thresh = value;
    @(posedge clk);
  endtask

  // Waits until every result has arrived, then lets the pipeline settle.
  task automatic drain();
    while (expected_closest.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic send_pair(pair_t pr);
    in_tvalid <= 1'b1;
    in_tdata <= pr;
    do @(posedge clk); while (!in_tready);
    expected_closest.push_back(closest_of(pr));
  endtask

  task automatic send_burst(int count);
    int burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) == 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
      burst--;
      send_pair(random_pair());
    end
    in_tvalid <= 1'b0;
  endtask

  // Receiver: a long hold-off when asked, otherwise its own stall pattern.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 255) < 200) || ($urandom_range(0, 1023) < 512);
    end
  end

  always @(posedge clk) begin
    closest_t got, want;
    if (out_tvalid && out_tready) begin
      got = closest_t'(out_tdata[289:0]);
      if (expected_closest.size() == 0) begin
        $error("result item with no expectation waiting");
        errors++;
      end else begin
        want = expected_closest.pop_front();
        if (got.s !== want.s) begin
          $error("first_param: expected %0d, got %0d", want.s, got.s); errors++; end
        if (got.t !== want.t) begin
          $error("second_param: expected %0d, got %0d", want.t, got.t); errors++; end
        if (got.p_x !== want.p_x) begin
          $error("first_point_x: expected %h, got %h", want.p_x, got.p_x); errors++; end
        if (got.p_y !== want.p_y) begin
          $error("first_point_y: expected %h, got %h", want.p_y, got.p_y); errors++; end
        if (got.p_z !== want.p_z) begin
          $error("first_point_z: expected %h, got %h", want.p_z, got.p_z); errors++; end
        if (got.q_x !== want.q_x) begin
          $error("second_point_x: expected %h, got %h", want.q_x, got.q_x); errors++; end
        if (got.q_y !== want.q_y) begin
          $error("second_point_y: expected %h, got %h", want.q_y, got.q_y); errors++; end
        if (got.q_z !== want.q_z) begin
          $error("second_point_z: expected %h, got %h", want.q_z, got.q_z); errors++; end
        if (got.dist_sq !== want.dist_sq) begin
          $error("distance_sq: expected %h, got %h", want.dist_sq, got.dist_sq); errors++; end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    logic [31:0] thr_values[4];
    int unsigned big;
    big = 32'h7FFF_FFFF;
    // Zero pair: both segments are points at the origin.
    rw.pair = '0; rw.typed = 1; rw.result = '0; rows.push_back(rw);
    // Two points one unit apart along x.
    rw.pair = make_pair(65536, 0, 0, 65536, 0, 0, 0, 0, 0, 0, 0, 0);
    rw.result = '0; rw.result.p_x = 65536; rw.result.dist_sq = 64'h1_0000_0000;
    rows.push_back(rw);
    // Points at opposite extremes: the distance saturates.
    rw.pair = make_pair(big, big, big, big, big, big,
                        -big - 1, -big - 1, -big - 1, -big - 1, -big - 1, -big - 1);
    rw.result = '0;
    rw.result.p_x = big; rw.result.p_y = big; rw.result.p_z = big;
    rw.result.q_x = -big - 1; rw.result.q_y = -big - 1; rw.result.q_z = -big - 1;
    rw.result.dist_sq = '1;
    rows.push_back(rw);
    rw.typed = 0;
    rw.pair = make_pair(-big - 1, big, 0, big, -big - 1, 0, big, big, -big - 1, -big - 1, 0, big);
    rows.push_back(rw);
    // Crossing, parallel, t below zero, t above one, one segment a point.
    rw.pair = make_pair(-65536, 0, 0, 65536, 0, 0, 0, -65536, 65536, 0, 65536, 65536);
    rows.push_back(rw);
    rw.pair = make_pair(0, 0, 0, 131072, 0, 0, 65536, 65536, 0, 196608, 65536, 0);
    rows.push_back(rw);
    rw.pair = make_pair(0, 0, 0, 131072, 0, 0, 0, 65536, 0, 0, 131072, 0);
    rows.push_back(rw);
    rw.pair = make_pair(0, 0, 0, 131072, 0, 0, 0, -131072, 0, 0, -65536, 0);
    rows.push_back(rw);
    rw.pair = make_pair(0, 0, 0, 131072, 0, 0, 0, 65536, 0, 0, 65536, 0);
    rows.push_back(rw);
    rw.pair = make_pair(65536, 65536, 0, 65536, 65536, 0, 0, 0, 0, 131072, 0, 0);
    rows.push_back(rw);
    rw.pair = make_pair(-65536, 0, 0, 65536, 0, 0, 0, 0, 0, 0, 0, 0);
    rows.push_back(rw);
    rw.pair = make_pair(0, 0, 0, 131072, 0, 0, 262144, 65536, 0, 393216, 65536, 0);
    rows.push_back(rw);
    // Segment whose squared length sits exactly at the reset threshold.
    rw.pair = make_pair(0, 0, 0, 654, 41, 10, 0, 65536, 0, 65536, 0, 0);
    rows.push_back(rw);
    rw.pair = make_pair(0, 0, 0, 0, -655, 0, 100, 200, 300, 70000, 200, 300);
    rows.push_back(rw);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_pair(rows[i].pair);
      if (rows[i].typed && expected_closest[$] != rows[i].result) begin
        $error("typed result of directed row %0d disagrees with the predictor", i);
        errors++;
      end
    end
    in_tvalid <= 1'b0;
    drain();

    thr_values = '{cpss_pkg::DEGEN_THR_RESET, 32'h0, 32'hFFFF_FFFF, $urandom()};
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        cfg_write((cpss_pkg::CFG_ADDR_W)'(4), $urandom());
        cfg_write('0, thr_values[ph]);
        if (cfg_prdata !== thr_values[ph]) begin
          $error("degenerate_threshold: expected %h, got %h", thr_values[ph], cfg_prdata);
          errors++;
        end
      end
      // The output stalls long enough for the pipeline to back up into the input.
      if (ph == 1) hold_cycles <= 300;
      send_burst(350);
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
